@@ hdl/ogeu_pkg.sv @@
// Shared types, codes and constants of the occupancy grid evidence update block.
package ogeu_pkg;

    // Default grid geometry
    localparam int GRID_WIDTH_DEF  = 280;
    localparam int GRID_HEIGHT_DEF = 150;

    // Queue depths
    localparam int JOB_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    // Evidence arithmetic
    localparam logic [6:0] COUNT_MAX    = 7'd100;
    localparam logic [7:0] BOOST_LIMIT  = 8'd100;
    localparam logic [7:0] BOOST_MARGIN = 8'd5;
    localparam logic [6:0] BOOST_STEP   = 7'd3;
    localparam logic [6:0] DECAY_STEP   = 7'd2;

    // Register reset values
    localparam logic signed [15:0] RST_ORIGIN_X = -16'sd2500;
    localparam logic signed [15:0] RST_ORIGIN_Y = -16'sd1875;
    localparam logic [15:0]        RST_INV_CELL = 16'd2621;
    localparam logic [9:0]         RST_BAND     = 10'd80;
    localparam logic [6:0]         RST_THRESH   = 7'd35;
    localparam logic               RST_SCAN     = 1'b0;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_INV_CELL = 3'd2,
        REG_BAND     = 3'd3,
        REG_THRESH   = 3'd4,
        REG_SCAN     = 3'd5
    } t_reg;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_POINT  = 2'd0,
        OP_COMMIT = 2'd1,
        OP_READ   = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    // Work codes passed from front to back
    typedef enum logic [1:0] {
        CMD_NOTE   = 2'd0,
        CMD_POINT  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_COMMIT = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DEC,
        F_MX,
        F_MY,
        F_IDX
    } t_fstate;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_RD,
        B_SWEEP,
        B_DRAIN
    } t_bstate;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [15:0]        inv_cell;
        logic [9:0]         band;
        logic [6:0]         thresh;
        logic               scan;
    } t_cfg;

    typedef struct packed {
        t_cmd        cmd;
        logic [1:0]  kind;
        logic [15:0] cell_res;
    } t_job;

    typedef struct packed {
        logic [6:0] count;
        logic       mask;
        logic       occ;
    } t_cell;

    typedef struct packed {
        logic [1:0]  kind;
        logic        counted;
        logic [15:0] cell_res;
        logic [6:0]  count;
        logic        occupied;
    } t_result;

endpackage

@@ hdl/ogeu_fifo.sv @@
// Small register queue used between front and back and on the result side.
module ogeu_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [PTR_W:0]    r_cnt;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // Store a pushed word
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PTR_W+1)'(w_wr) - (PTR_W+1)'(w_rd);
        end
    end

endmodule

@@ hdl/ogeu_front.sv @@
// Front end: takes input items, maps points to cells and queues work for the back end.
module ogeu_front #(
    parameter int GRID_WIDTH  = ogeu_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ogeu_pkg::GRID_HEIGHT_DEF,
    parameter int ADDR_W      = $clog2(GRID_WIDTH * GRID_HEIGHT)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ogeu_pkg::t_cfg     i_cfg,
    input  logic               i_hold,
    input  logic               i_push,
    output logic               o_full,
    input  logic [1:0]         i_op,
    input  logic signed [15:0] i_x_mm,
    input  logic signed [15:0] i_y_mm,
    input  logic [15:0]        i_cell_index,
    input  logic               i_q_full,
    output logic               o_q_push,
    output ogeu_pkg::t_job     o_q_job,
    output logic [ADDR_W-1:0]  o_q_idx
);
    import ogeu_pkg::*;

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int COL_W = $clog2(GRID_WIDTH);
    localparam int ROW_W = $clog2(GRID_HEIGHT);

    t_fstate            r_state;
    t_fstate            n_state;
    t_op                r_op;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic [15:0]        r_ci;
    logic [16:0]        r_qx;
    logic               r_negx;
    logic [16:0]        r_qy;
    logic               r_negy;

    logic               w_accept;
    logic [15:0]        w_pos;
    logic [15:0]        w_org;
    logic [16:0]        w_diff;
    logic               w_neg;
    logic [16:0]        w_mag;
    logic [32:0]        w_prod;
    logic [16:0]        w_ay;
    logic               w_in_band;
    logic               w_col_ok;
    logic               w_row_ok;
    logic [ADDR_W-1:0]  w_pt_idx;
    logic               w_read_ok;

    assign o_full   = (r_state != F_IDLE) || i_hold;
    assign w_accept = i_push && !o_full;

    // Shared multiplier: x in F_MX, y in F_MY
    assign w_pos  = (r_state == F_MY) ? r_y : r_x;
    assign w_org  = (r_state == F_MY) ? i_cfg.origin_y : i_cfg.origin_x;
    assign w_diff = {w_pos[15], w_pos} - {w_org[15], w_org};
    assign w_neg  = w_diff[16];
    assign w_mag  = w_neg ? (17'd0 - w_diff) : w_diff;
    assign w_prod = 33'(w_mag) * 33'(i_cfg.inv_cell);

    // Band test on |y|
    assign w_ay      = r_y[15] ? (17'd0 - {1'b1, r_y}) : {1'b0, r_y};
    assign w_in_band = (w_ay <= 17'(i_cfg.band));

    // Grid bounds; a negative quotient of zero still lands in cell zero
    assign w_col_ok  = (r_qx == '0) || (!r_negx && (r_qx < 17'(GRID_WIDTH)));
    assign w_row_ok  = (r_qy == '0) || (!r_negy && (r_qy < 17'(GRID_HEIGHT)));
    assign w_pt_idx  = ADDR_W'(r_qy[ROW_W-1:0]) * ADDR_W'(GRID_WIDTH)
                     + ADDR_W'(r_qx[COL_W-1:0]);
    assign w_read_ok = (32'(r_ci) < 32'(CELLS));

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Item fields and mapped coordinates
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= t_op'(i_op);
            r_x  <= i_x_mm;
            r_y  <= i_y_mm;
            r_ci <= i_cell_index;
        end
        if (r_state == F_MX) begin
            r_qx   <= w_prod[32:16];
            r_negx <= w_neg;
        end
        if (r_state == F_MY) begin
            r_qy   <= w_prod[32:16];
            r_negy <= w_neg;
        end
    end

    // Classify items and push work
    always_comb begin
        n_state          = r_state;
        o_q_push         = 1'b0;
        o_q_job.cmd      = CMD_NOTE;
        o_q_job.kind     = r_op;
        o_q_job.cell_res = '0;
        o_q_idx          = '0;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_state = F_DEC;
                end
            end
            F_DEC: begin
                if (r_op == OP_POINT && !w_in_band) begin
                    n_state = F_MX;
                end else begin
                    unique case (r_op)
                        OP_COMMIT: o_q_job.cmd = CMD_COMMIT;
                        OP_READ: begin
                            o_q_job.cell_res = r_ci;
                            if (w_read_ok) begin
                                o_q_job.cmd = CMD_READ;
                                o_q_idx     = ADDR_W'(r_ci);
                            end
                        end
                        OP_POINT, OP_UNUSED: o_q_job.cmd = CMD_NOTE;
                    endcase
                    o_q_push = !i_q_full;
                    if (!i_q_full) begin
                        n_state = F_IDLE;
                    end
                end
            end
            F_MX: n_state = F_MY;
            F_MY: n_state = F_IDX;
            F_IDX: begin
                if (w_col_ok && w_row_ok) begin
                    o_q_job.cmd      = CMD_POINT;
                    o_q_job.cell_res = 16'(w_pt_idx);
                    o_q_idx          = w_pt_idx;
                end
                o_q_push = !i_q_full;
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

endmodule

@@ hdl/ogeu_back.sv @@
// Back end: owns the cell memory, clears it after reset, runs hits, reads and sweeps.
module ogeu_back #(
    parameter int GRID_WIDTH  = ogeu_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ogeu_pkg::GRID_HEIGHT_DEF,
    parameter int ADDR_W      = $clog2(GRID_WIDTH * GRID_HEIGHT)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ogeu_pkg::t_cfg    i_cfg,
    input  logic              i_job_empty,
    input  ogeu_pkg::t_job    i_job,
    input  logic [ADDR_W-1:0] i_job_idx,
    output logic              o_job_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output ogeu_pkg::t_result o_res,
    output logic              o_clearing
);
    import ogeu_pkg::*;

    localparam int              CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(CELLS - 1);

    t_cell             r_mem [CELLS];
    t_cell             r_rdata;

    t_bstate           r_state;
    t_bstate           n_state;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] n_addr;
    logic [ADDR_W-1:0] r_wb_addr;
    logic [ADDR_W-1:0] n_wb_addr;
    logic              r_swv;
    logic              n_swv;
    t_job              r_job;
    t_job              n_job;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] n_idx;

    logic [ADDR_W-1:0] w_raddr;
    logic [ADDR_W-1:0] w_waddr;
    logic              w_we;
    t_cell             w_wdata;
    t_cell             w_swept;
    t_cell             w_hit;
    logic              w_sat;

    // Cell memory: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // Sweep update of one cell: decay or boost unless scan is set, conclude, clear mask
    always_comb begin
        w_swept = r_rdata;
        if (!r_rdata.mask) begin
            if (!i_cfg.scan) begin
                w_swept.count = (r_rdata.count > DECAY_STEP) ?
                                (r_rdata.count - DECAY_STEP) : '0;
            end
        end else if ((8'(r_rdata.count) + BOOST_MARGIN) < BOOST_LIMIT) begin
            if (!i_cfg.scan) begin
                w_swept.count = r_rdata.count + BOOST_STEP;
            end
        end
        if (w_swept.count > i_cfg.thresh) begin
            w_swept.occ = 1'b1;
        end else if (w_swept.count == '0) begin
            w_swept.occ = 1'b0;
        end
        w_swept.mask = 1'b0;
    end

    // Hit on one cell: count up and mark unless saturated
    assign w_sat = (r_rdata.count >= COUNT_MAX);
    always_comb begin
        w_hit = r_rdata;
        if (!w_sat) begin
            w_hit.count = r_rdata.count + 7'd1;
            w_hit.mask  = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_addr  <= '0;
            r_swv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_swv   <= n_swv;
        end
    end

    // Held job and write-back address
    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_idx     <= n_idx;
        r_wb_addr <= n_wb_addr;
    end

    // Sequence jobs over the memory
    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_wb_addr  = r_wb_addr;
        n_swv      = 1'b0;
        n_job      = r_job;
        n_idx      = r_idx;
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        o_clearing = 1'b0;
        w_raddr    = r_addr;
        w_we       = 1'b0;
        w_waddr    = r_wb_addr;
        w_wdata    = w_swept;
        unique case (r_state)
            B_CLEAR: begin
                o_clearing = 1'b1;
                w_we       = 1'b1;
                w_waddr    = r_addr;
                w_wdata    = '0;
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = B_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            B_IDLE: begin
                w_raddr = i_job_idx;
                if (!i_job_empty && !i_res_full) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_idx     = i_job_idx;
                    unique case (i_job.cmd)
                        CMD_NOTE: begin
                            o_res_push     = 1'b1;
                            o_res.kind     = i_job.kind;
                            o_res.cell_res = i_job.cell_res;
                        end
                        CMD_POINT, CMD_READ: n_state = B_RD;
                        CMD_COMMIT: begin
                            n_addr  = '0;
                            n_state = B_SWEEP;
                        end
                    endcase
                end
            end
            B_RD: begin
                o_res_push     = 1'b1;
                o_res.kind     = r_job.kind;
                o_res.cell_res = r_job.cell_res;
                o_res.occupied = r_rdata.occ;
                o_res.count    = r_rdata.count;
                if (r_job.cmd == CMD_POINT) begin
                    o_res.counted = !w_sat;
                    o_res.count   = w_hit.count;
                    w_we          = !w_sat;
                    w_waddr       = r_idx;
                    w_wdata       = w_hit;
                end
                n_state = B_IDLE;
            end
            B_SWEEP: begin
                w_raddr   = r_addr;
                n_swv     = 1'b1;
                n_wb_addr = r_addr;
                w_we      = r_swv;
                if (r_addr == LAST) begin
                    n_state = B_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            B_DRAIN: begin
                w_we           = r_swv;
                o_res_push     = 1'b1;
                o_res.kind     = r_job.kind;
                o_res.cell_res = r_job.cell_res;
                n_state        = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

endmodule

@@ hdl/occupancy_grid_evidence_update.sv @@
// Top level of the occupancy grid evidence update block.
//
// Input items enter through a queue-style port: an item is taken on a clock edge
// with i_push high and o_full low. op 0 adds a point (x, y in mm), op 1 commits the
// batch with a sweep over every cell, op 2 reads one cell. Each item gives exactly
// one result, shown on the o_ result ports while o_empty is low and taken with
// i_pop. Registers are written over i_cfg_valid/o_cfg_ready, index i_cfg_index.
// A point is mapped through decode, x scale, y scale and row-major index steps with
// one shared multiplier, then updated by a read-modify-write of the cell memory.
// The front end takes no new item until it has queued the work of the last one.
// A commit sweeps every cell in the back end, one cell a cycle.
// After reset the cell memory is cleared one cell a cycle and o_full stays high
// meanwhile; registers may be written during that time. A stalled receiver fills
// the two-entry result queue, then the four-entry job queue, and then o_full rises;
// no result is dropped.
module occupancy_grid_evidence_update #(
    parameter int GRID_WIDTH  = ogeu_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ogeu_pkg::GRID_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_push,
    output logic               o_full,
    input  logic [1:0]         i_op,
    input  logic signed [15:0] i_x_mm,
    input  logic signed [15:0] i_y_mm,
    input  logic [15:0]        i_cell_index,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [1:0]         o_kind,
    output logic               o_counted,
    output logic [15:0]        o_cell_res,
    output logic [6:0]         o_count,
    output logic               o_occupied
);
    import ogeu_pkg::*;

    localparam int ADDR_W = $clog2(GRID_WIDTH * GRID_HEIGHT);
    localparam int JOB_W  = $bits(t_job) + ADDR_W;
    localparam int RES_W  = $bits(t_result);

    t_cfg              r_cfg;
    logic              w_cfg_we;

    logic              w_front_full;
    logic              w_clearing;
    logic              w_jq_push;
    logic              w_jq_full;
    logic              w_jq_empty;
    logic              w_jq_pop;
    t_job              w_front_job;
    logic [ADDR_W-1:0] w_front_idx;
    logic [JOB_W-1:0]  w_jq_out;
    t_job              w_back_job;
    logic [ADDR_W-1:0] w_back_idx;

    logic              w_rq_push;
    logic              w_rq_full;
    t_result           w_back_res;
    t_result           w_out_res;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x <= RST_ORIGIN_X;
            r_cfg.origin_y <= RST_ORIGIN_Y;
            r_cfg.inv_cell <= RST_INV_CELL;
            r_cfg.band     <= RST_BAND;
            r_cfg.thresh   <= RST_THRESH;
            r_cfg.scan     <= RST_SCAN;
        end else if (w_cfg_we) begin
            unique case (t_reg'(i_cfg_index))
                REG_ORIGIN_X: r_cfg.origin_x <= i_cfg_data;
                REG_ORIGIN_Y: r_cfg.origin_y <= i_cfg_data;
                REG_INV_CELL: r_cfg.inv_cell <= i_cfg_data;
                REG_BAND:     r_cfg.band     <= i_cfg_data[9:0];
                REG_THRESH:   r_cfg.thresh   <= i_cfg_data[6:0];
                REG_SCAN:     r_cfg.scan     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Front end
    ogeu_front #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_hold       (w_clearing),
        .i_push       (i_push),
        .o_full       (w_front_full),
        .i_op         (i_op),
        .i_x_mm       (i_x_mm),
        .i_y_mm       (i_y_mm),
        .i_cell_index (i_cell_index),
        .i_q_full     (w_jq_full),
        .o_q_push     (w_jq_push),
        .o_q_job      (w_front_job),
        .o_q_idx      (w_front_idx)
    );

    assign o_full = w_front_full;

    // Job queue between front and back
    ogeu_fifo #(
        .DATA_W (JOB_W),
        .DEPTH  (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_jq_push),
        .i_data  ({w_front_job, w_front_idx}),
        .o_full  (w_jq_full),
        .i_pop   (w_jq_pop),
        .o_data  (w_jq_out),
        .o_empty (w_jq_empty)
    );

    assign w_back_job = t_job'(w_jq_out[JOB_W-1:ADDR_W]);
    assign w_back_idx = w_jq_out[ADDR_W-1:0];

    // Back end
    ogeu_back #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_empty (w_jq_empty),
        .i_job       (w_back_job),
        .i_job_idx   (w_back_idx),
        .o_job_pop   (w_jq_pop),
        .i_res_full  (w_rq_full),
        .o_res_push  (w_rq_push),
        .o_res       (w_back_res),
        .o_clearing  (w_clearing)
    );

    // Result queue toward the receiver
    ogeu_fifo #(
        .DATA_W (RES_W),
        .DEPTH  (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rq_push),
        .i_data  (w_back_res),
        .o_full  (w_rq_full),
        .i_pop   (i_pop),
        .o_data  (w_out_res),
        .o_empty (o_empty)
    );

    assign o_kind     = w_out_res.kind;
    assign o_counted  = w_out_res.counted;
    assign o_cell_res = w_out_res.cell_res;
    assign o_count    = w_out_res.count;
    assign o_occupied = w_out_res.occupied;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the occupancy grid evidence update block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ogeu_pkg::*;

    localparam int GRID_W      = GRID_WIDTH_DEF;
    localparam int GRID_H      = GRID_HEIGHT_DEF;
    localparam int CELLS       = GRID_W * GRID_H;
    localparam int HOT_N       = 4;
    localparam int QUIET_LIMIT = 4 * CELLS + 20000;

    logic               i_clk;
    logic               i_rst_n      = 1'b0;
    logic               i_cfg_valid  = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index  = '0;
    logic [15:0]        i_cfg_data   = '0;
    logic               i_push       = 1'b0;
    logic               o_full;
    logic [1:0]         i_op         = '0;
    logic signed [15:0] i_x_mm       = '0;
    logic signed [15:0] i_y_mm       = '0;
    logic [15:0]        i_cell_index = '0;
    logic               o_empty;
    logic               i_pop        = 1'b0;
    logic [1:0]         o_kind;
    logic               o_counted;
    logic [15:0]        o_cell_res;
    logic [6:0]         o_count;
    logic               o_occupied;

    // Mirror of the grid stores and registers
    bit [6:0] cell_count [CELLS];
    bit       cell_mark  [CELLS];
    bit       cell_occ   [CELLS];
    int       org_x, org_y, inv_q16, band_lim, thresh;
    bit       scan_on;

    t_result  due_results [$];
    t_result  got_word, want_word;
    int       fault_count    = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    int       hold_pops      = 0;
    int       quiet_cycles   = 0;
    int       last_cell      = 0;
    bit       commit_last    = 1'b0;
    int       hot_col [HOT_N];
    int       hot_row [HOT_N];

    occupancy_grid_evidence_update u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_op         (i_op),
        .i_x_mm       (i_x_mm),
        .i_y_mm       (i_y_mm),
        .i_cell_index (i_cell_index),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_kind       (o_kind),
        .o_counted    (o_counted),
        .o_cell_res   (o_cell_res),
        .o_count      (o_count),
        .o_occupied   (o_occupied)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void note_error(string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t ERROR: %s", $time, msg);
        end
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Scale the offset from the origin, truncating toward zero
    function automatic int axis_cell(int pos, int org);
        longint d, m, q;
        d = longint'(pos) - longint'(org);
        m = (d < 0) ? -d : d;
        q = (m * longint'(inv_q16)) >>> 16;
        return int'((d < 0) ? -q : q);
    endfunction

    // Pick a position that maps into the given slot under the current scale
    function automatic logic signed [15:0] place_on_axis(int slot, int org);
        longint lo, hi, span;
        lo   = (longint'(slot) * 65536 + inv_q16 - 1) / inv_q16;
        hi   = (longint'(slot + 1) * 65536 + inv_q16 - 1) / inv_q16 - 1;
        span = (hi - lo > 1000) ? 1000 : hi - lo;
        return clamp16(longint'(org) + lo + longint'($urandom_range(int'(span))));
    endfunction

    // Advance the grid mirror by one word and return the result it produces
    function automatic t_result grid_apply(t_op op, logic signed [15:0] x,
                                           logic signed [15:0] y, logic [15:0] idx);
        t_result r;
        int ay, col, row, cix, c;
        r      = '0;
        r.kind = op;
        case (op)
            OP_POINT: begin
                ay = (y < 0) ? -int'(y) : int'(y);
                if (ay > band_lim) begin
                    col = axis_cell(int'(x), org_x);
                    row = axis_cell(int'(y), org_y);
                    if (col >= 0 && col < GRID_W && row >= 0 && row < GRID_H) begin
                        cix       = row * GRID_W + col;
                        last_cell = cix;
                        if (cell_count[cix] < COUNT_MAX) begin
                            cell_count[cix] = cell_count[cix] + 7'd1;
                            cell_mark[cix]  = 1'b1;
                            r.counted       = 1'b1;
                        end
                        r.cell_res = cix[15:0];
                        r.count    = cell_count[cix];
                        r.occupied = cell_occ[cix];
                    end
                end
            end
            OP_COMMIT: begin
                for (cix = 0; cix < CELLS; cix++) begin
                    c = int'(cell_count[cix]);
                    if (!cell_mark[cix]) begin
                        if (!scan_on) begin
                            c = (c > int'(DECAY_STEP)) ? c - int'(DECAY_STEP) : 0;
                        end
                    end else if (c + int'(BOOST_MARGIN) < int'(BOOST_LIMIT)) begin
                        if (!scan_on) begin
                            c = c + int'(BOOST_STEP);
                        end
                    end
                    cell_count[cix] = c[6:0];
                    if (c > thresh) begin
                        cell_occ[cix] = 1'b1;
                    end else if (c == 0) begin
                        cell_occ[cix] = 1'b0;
                    end
                    cell_mark[cix] = 1'b0;
                end
            end
            OP_READ: begin
                r.cell_res = idx;
                if (int'(idx) < CELLS) begin
                    r.count    = cell_count[idx];
                    r.occupied = cell_occ[idx];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offer one word, hold it until taken, then log its expected result
    task automatic offer_word(t_op op, logic signed [15:0] x, logic signed [15:0] y,
                              logic [15:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_push <= 1'b0;
        end
        @(negedge i_clk);
        i_push       <= 1'b1;
        i_op         <= op;
        i_x_mm       <= x;
        i_y_mm       <= y;
        i_cell_index <= idx;
        do @(posedge i_clk); while (o_full);
        due_results.insert(due_results.size(), grid_apply(op, x, y, idx));
        commit_last = (op == OP_COMMIT);
    endtask

    // Drop push and wait until every expected result is back
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (due_results.size() != 0) begin
            @(posedge i_clk);
        end
        if (commit_last) begin
            repeat (CELLS + 64) @(posedge i_clk);
        end else begin
            repeat (16) @(posedge i_clk);
        end
        commit_last = 1'b0;
    endtask

    task automatic write_reg(t_reg r, int v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= v[15:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (r)
            REG_ORIGIN_X: org_x    = int'($signed(v[15:0]));
            REG_ORIGIN_Y: org_y    = int'($signed(v[15:0]));
            REG_INV_CELL: inv_q16  = int'(v[15:0]);
            REG_BAND:     band_lim = int'(v[9:0]);
            REG_THRESH:   thresh   = int'(v[6:0]);
            REG_SCAN:     scan_on  = v[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_config(int ox, int oy, int inv, int band, int thr, int scan);
        wait_for_drain();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_INV_CELL, inv);
        write_reg(REG_BAND, band);
        write_reg(REG_THRESH, thr);
        write_reg(REG_SCAN, scan);
    endtask

    task automatic set_gaps(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Mostly hits inside the grid, a hot set to drive saturation, then noise
    task automatic pick_point(output logic signed [15:0] px, output logic signed [15:0] py);
        int mode, h;
        mode = $urandom_range(99);
        h    = $urandom_range(HOT_N - 1);
        if (mode < 35) begin
            px = place_on_axis(hot_col[h], org_x);
            py = place_on_axis(hot_row[h], org_y);
        end else if (mode < 78) begin
            px = place_on_axis($urandom_range(GRID_W - 1), org_x);
            py = place_on_axis($urandom_range(GRID_H - 1), org_y);
        end else if (mode < 85) begin
            // just below the origin: truncation lands in column zero or just out
            px = clamp16(longint'(org_x) - longint'($urandom_range(65535 / inv_q16 + 2)));
            py = place_on_axis($urandom_range(GRID_H - 1), org_y);
        end else if (mode < 92) begin
            px = 16'($urandom);
            py = clamp16($urandom_range(1) ? -int'($urandom_range(band_lim))
                                           : int'($urandom_range(band_lim)));
        end else begin
            px = 16'($urandom);
            py = 16'($urandom);
        end
    endtask

    function automatic logic [15:0] pick_cell();
        int mode, h;
        mode = $urandom_range(99);
        h    = $urandom_range(HOT_N - 1);
        if (mode < 40) begin
            return 16'(hot_row[h] * GRID_W + hot_col[h]);
        end else if (mode < 60) begin
            return 16'(last_cell);
        end else if (mode < 85) begin
            return 16'($urandom_range(CELLS - 1));
        end
        return 16'($urandom);
    endfunction

    task automatic send_mixed();
        int mode;
        logic signed [15:0] px, py;
        mode = $urandom_range(99);
        if (mode < 76) begin
            pick_point(px, py);
            offer_word(OP_POINT, px, py, 16'($urandom));
        end else if (mode < 94) begin
            offer_word(OP_READ, 16'($urandom), 16'($urandom), pick_cell());
        end else begin
            offer_word(OP_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    // Batches of points, reads and unused ops, each closed by a commit and a read
    task automatic run_batches(int n, int commits);
        int k;
        for (k = 0; k < commits; k++) begin
            repeat (n / commits) send_mixed();
            offer_word(OP_COMMIT, 16'($urandom), 16'($urandom), 16'($urandom));
            offer_word(OP_READ, 16'($urandom), 16'($urandom), pick_cell());
        end
    endtask

    task automatic test_register_setup();
        int h;
        for (h = 0; h < HOT_N; h++) begin
            hot_col[h] = $urandom_range(GRID_W - 1);
            hot_row[h] = $urandom_range(1) ? $urandom_range(60) : $urandom_range(GRID_H - 1, 90);
        end
        apply_config(int'(RST_ORIGIN_X), int'(RST_ORIGIN_Y), int'(RST_INV_CELL),
                     int'(RST_BAND), int'(RST_THRESH), int'(RST_SCAN));
    endtask

    task automatic test_directed_cases();
        set_gaps(0, 0);
        // band edges
        offer_word(OP_POINT, 0, 0, 16'hFFFF);
        offer_word(OP_POINT, 0, 80, 16'h0000);
        offer_word(OP_POINT, 123, -80, 16'h1234);
        // ordinary hit, small negative offsets, grid corners
        offer_word(OP_POINT, 0, 81, 16'h0000);
        offer_word(OP_POINT, -2510, 100, 16'h0000);
        offer_word(OP_POINT, -2500, -1875, 16'h0000);
        offer_word(OP_POINT, -2499, -1900, 16'h0000);
        offer_word(OP_POINT, 4499, 1874, 16'h0000);
        // outside the grid
        offer_word(OP_POINT, 4510, 500, 16'h0000);
        offer_word(OP_POINT, -32768, 32767, 16'h0000);
        offer_word(OP_POINT, 32767, -32768, 16'h0000);
        offer_word(OP_POINT, -32768, -32768, 16'h0000);
        offer_word(OP_POINT, 32767, 32767, 16'h0000);
        // reads in and out of range
        offer_word(OP_READ, 0, 0, 16'd0);
        offer_word(OP_READ, 0, 0, 16'd21939);
        offer_word(OP_READ, 0, 0, 16'(CELLS - 1));
        offer_word(OP_READ, 0, 0, 16'(CELLS));
        offer_word(OP_READ, -1, -1, 16'hFFFF);
        offer_word(OP_UNUSED, -1, -1, 16'hFFFF);
        offer_word(OP_COMMIT, 0, 0, 16'h0000);
        offer_word(OP_READ, 0, 0, 16'd0);
        offer_word(OP_READ, 0, 0, 16'd21939);
        offer_word(OP_READ, 0, 0, 16'(CELLS - 1));
        offer_word(OP_READ, 0, 0, 16'd100);
    endtask

    task automatic test_idle_phases();
        set_gaps(0, 0);
        run_batches(200, 2);
        set_gaps(68, 0);
        run_batches(200, 2);
        set_gaps(0, 68);
        run_batches(200, 2);
        set_gaps(29, 29);
        run_batches(200, 2);
    endtask

    task automatic test_config_extremes();
        set_gaps(29, 29);
        // one millimetre cells, no band, any count occupies
        apply_config(-100, -60, 65535, 0, 0, 0);
        run_batches(40, 1);
        // huge cells, a 1000 mm band, threshold never reached, sweep frozen
        apply_config(-32768, -32768, 1, 1000, 100, 1);
        run_batches(40, 1);
        // origin at the top corner
        apply_config(32767, 32767, 6553, 999, 11, 1);
        run_batches(40, 1);
        apply_config(-int'($urandom_range(4000)), -int'($urandom_range(3000)),
                     $urandom_range(8000, 1000), $urandom_range(1000),
                     $urandom_range(100), $urandom_range(1));
        run_batches(40, 1);
        apply_config(int'(RST_ORIGIN_X), int'(RST_ORIGIN_Y), int'(RST_INV_CELL),
                     int'(RST_BAND), int'(RST_THRESH), int'(RST_SCAN));
        run_batches(40, 1);
    endtask

    task automatic test_backpressure();
        logic signed [15:0] px, py;
        set_gaps(0, 0);
        @(posedge i_clk);
        hold_pops = 400;
        // keep offering while results back up until push is refused
        repeat (24) begin
            pick_point(px, py);
            offer_word(OP_POINT, px, py, 16'($urandom));
        end
        wait_for_drain();
        repeat (20) send_mixed();
    endtask

    // Result side: random pops, with an occasional long hold
    always @(negedge i_clk) begin
        if (hold_pops > 0) begin
            hold_pops--;
            i_pop <= 1'b0;
        end else begin
            i_pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each popped word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            got_word = {o_kind, o_counted, o_cell_res, o_count, o_occupied};
            if (due_results.size() == 0) begin
                note_error($sformatf("unexpected word kind %0d cell %0d", o_kind, o_cell_res));
            end else begin
                want_word = due_results.pop_front();
                if (got_word !== want_word) begin
                    note_error($sformatf({"expected kind %0d counted %0b cell %0d count %0d ",
                        "occ %0b, got kind %0d counted %0b cell %0d count %0d occ %0b"},
                        want_word.kind, want_word.counted, want_word.cell_res,
                        want_word.count, want_word.occupied, got_word.kind,
                        got_word.counted, got_word.cell_res, got_word.count,
                        got_word.occupied));
                end
            end
        end
    end

    // Stop a hung run: count cycles with no word moving on any port
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_register_setup();
        test_directed_cases();
        test_idle_phases();
        test_config_extremes();
        test_backpressure();
        wait_for_drain();
        repeat (64) @(posedge i_clk);
        if (fault_count == 0 && due_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/ogeu_pkg.sv
hdl/ogeu_fifo.sv
hdl/ogeu_front.sv
hdl/ogeu_back.sv
hdl/occupancy_grid_evidence_update.sv
tb/tb.sv
